/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property templates, clocked on i_clk, off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

/* hdl/nec_pkg.sv */
// ----------------------------------------------------------------------------
// nec_pkg
// Types and constants shared by the epsilon-closure controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nec_pkg;

    localparam int STATE_W = 4;
    localparam int SET_W   = 16;

    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_CLOSE = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    typedef struct packed {
        logic write_edge;
        logic load_set;
        logic step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic converged;
    } t_stat;

endpackage

/* hdl/nec_ctrl.sv */
// ----------------------------------------------------------------------------
// nec_ctrl
// Sequencer: takes transactions, runs closure passes, hands off the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nec_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic          i_mode,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output nec_pkg::t_cmd o_cmd,
    input  nec_pkg::t_stat i_stat
);
    import nec_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_mode == MODE_CLOSE) begin
                        o_cmd.load_set = 1'b1;
                        n_state        = S_RUN;
                    end else begin
                        o_cmd.write_edge = 1'b1;
                    end
                end
            end
            S_RUN: begin
                o_cmd.step = 1'b1;
                // hold the closed set until the output register frees up
                if (i_stat.converged && w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* hdl/nec_dp.sv */
// ----------------------------------------------------------------------------
// nec_dp
// Edge store, working set register with one OR pass per cycle, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nec_dp #(
    parameter int NUM_STATES = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  nec_pkg::t_cmd               i_cmd,
    output nec_pkg::t_stat              o_stat,
    input  logic [nec_pkg::STATE_W-1:0] i_from_state,
    input  logic [nec_pkg::STATE_W-1:0] i_to_state,
    input  logic [nec_pkg::SET_W-1:0]   i_start_set,
    output logic [nec_pkg::SET_W-1:0]   o_closure_set
);
    import nec_pkg::*;

    // states that exist: below NUM_STATES and representable in the fields
    localparam int                 LP_ROWS   = (NUM_STATES < SET_W) ? NUM_STATES : SET_W;
    localparam int                 LP_IDX_W  = $clog2(LP_ROWS);
    localparam logic [STATE_W:0]   LP_ROWS_V = (STATE_W + 1)'(LP_ROWS);
    localparam logic [SET_W-1:0]   LP_MASK   = SET_W'((32'd1 << LP_ROWS) - 32'd1);

    logic [SET_W-1:0] r_edges [LP_ROWS];
    logic [SET_W-1:0] r_cur;
    logic [SET_W-1:0] r_out;
    logic [SET_W-1:0] w_next;
    logic [SET_W-1:0] w_to_bit;
    logic             w_edge_ok;

    assign w_edge_ok = ({1'b0, i_from_state} < LP_ROWS_V) && ({1'b0, i_to_state} < LP_ROWS_V);
    assign w_to_bit  = SET_W'(1) << i_to_state;

    // one closure pass: OR in the row of every current member
    always_comb begin
        w_next = r_cur;
        for (int i = 0; i < LP_ROWS; i++) begin
            if (r_cur[i]) begin
                w_next = w_next | r_edges[i];
            end
        end
        w_next = w_next & LP_MASK;
    end

    assign o_stat.converged = (w_next == r_cur);
    assign o_closure_set    = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LP_ROWS; i++) begin
                r_edges[i] <= '0;
            end
        end else if (i_cmd.write_edge && w_edge_ok) begin
            r_edges[i_from_state[LP_IDX_W-1:0]] <=
                r_edges[i_from_state[LP_IDX_W-1:0]] | w_to_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_set) begin
            r_cur <= i_start_set & LP_MASK;
        end else if (i_cmd.step) begin
            r_cur <= w_next;
        end
        if (i_cmd.load_out) begin
            r_out <= r_cur;
        end
    end

endmodule

/* hdl/nfa_epsilon_closure.sv */
// ----------------------------------------------------------------------------
// nfa_epsilon_closure
// An add-edge transaction (mode 0) sets one epsilon edge in a register store
// of one 16-bit row per state; edges touching a state at or above NUM_STATES
// are dropped. A closure transaction (mode 1) loads the start set, masked to
// existing states, then makes one pass per cycle that ORs in the rows of all
// current members, until a pass adds nothing. Input stalls while a closure
// runs or its closed set waits for the output register; a finished result
// waits in an output register, so add-edge transactions keep flowing while it
// is not yet taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nfa_epsilon_closure #(
    parameter int NUM_STATES = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_mode,
    input  logic [nec_pkg::STATE_W-1:0] i_from_state,
    input  logic [nec_pkg::STATE_W-1:0] i_to_state,
    input  logic [nec_pkg::SET_W-1:0]   i_start_set,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [nec_pkg::SET_W-1:0]   o_closure_set
);
    import nec_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    nec_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_mode      (i_mode),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    nec_dp #(
        .NUM_STATES (NUM_STATES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_from_state  (i_from_state),
        .i_to_state    (i_to_state),
        .i_start_set   (i_start_set),
        .o_closure_set (o_closure_set)
    );

    // a closure transaction always occupies the engine for the next cycle
    `ASSERT_NEXT(a_close_busy, i_in_valid && !o_in_stall && (i_mode == MODE_CLOSE), o_in_stall)
    // an edge write never stalls the input
    `ASSERT_NEXT(a_add_idle, i_in_valid && !o_in_stall && (i_mode == MODE_ADD), !o_in_stall)
    // a fresh result appears only as a closure run finishes
    `ASSERT_SAME(a_result_src, $rose(o_out_valid), $fell(o_in_stall))
    // a result is never loaded while the datapath is being told to load a new set
    `ASSERT_SAME(a_cmd_excl, w_cmd.load_out, !w_cmd.load_set && !w_cmd.write_edge)

endmodule

/* verif/nfa_epsilon_closure_checker.sv */
// ----------------------------------------------------------------------------
// nfa_epsilon_closure_checker
// Watches both channels of the epsilon-closure block. It keeps its own copy
// of the edge store, predicts the closed set when a closure transaction is
// accepted, and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nfa_epsilon_closure_checker #(
    parameter int NUM_STATES = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic                        i_mode,
    input  logic [nec_pkg::STATE_W-1:0] i_from_state,
    input  logic [nec_pkg::STATE_W-1:0] i_to_state,
    input  logic [nec_pkg::SET_W-1:0]   i_start_set,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic [nec_pkg::SET_W-1:0]   i_closure_set,
    output int                          o_fail_count,
    output int                          o_pending
);
    import nec_pkg::*;

    localparam int MAX_REPORTS = 10;
    localparam logic [SET_W-1:0] LIVE_MASK =
        (NUM_STATES >= SET_W) ? {SET_W{1'b1}} : SET_W'((1 << NUM_STATES) - 1);

    logic [SET_W-1:0] eps_rows [SET_W];
    logic [SET_W-1:0] closure_q [$];
    int               fails = 0;
    int               pending = 0;

    assign o_fail_count = fails;
    assign o_pending    = pending;

    function automatic bit live_state(input logic [STATE_W-1:0] s);
        return int'(s) < NUM_STATES;
    endfunction

    // Grow the set by the rows of its members until a pass adds nothing.
    function automatic logic [SET_W-1:0] close_over_edges(input logic [SET_W-1:0] seed);
        logic [SET_W-1:0] cur;
        logic [SET_W-1:0] grown;
        cur = seed & LIVE_MASK;
        for (int pass = 0; pass < SET_W; pass++) begin
            grown = cur;
            for (int s = 0; s < SET_W; s++) begin
                if (cur[s])
                    grown |= eps_rows[s];
            end
            grown &= LIVE_MASK;
            if (grown == cur)
                break;
            cur = grown;
        end
        return cur;
    endfunction

    always @(posedge i_clk) begin
        logic [SET_W-1:0] want;
        if (!i_rst_n) begin
            for (int r = 0; r < SET_W; r++)
                eps_rows[r] = '0;
            closure_q.delete();
        end else begin
            // Compare first: a result taken on this edge never comes from
            // a closure taken on the same edge.
            if (i_out_valid && !i_out_stall) begin
                if (closure_q.size() == 0) begin
                    fails++;
                    if (fails <= MAX_REPORTS)
                        $display("%0t: closure result %h with none pending",
                                 $time, i_closure_set);
                end else begin
                    want = closure_q.pop_front();
                    if (i_closure_set !== want) begin
                        fails++;
                        if (fails <= MAX_REPORTS)
                            $display("%0t: closure_set mismatch: expected %h, actual %h",
                                     $time, want, i_closure_set);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_mode == MODE_ADD) begin
                    if (live_state(i_from_state) && live_state(i_to_state))
                        eps_rows[i_from_state][i_to_state] = 1'b1;
                end else begin
                    // append the prediction behind the older ones
                    closure_q = {closure_q, close_over_edges(i_start_set)};
                end
            end
        end
        pending = closure_q.size();
    end

endmodule

/* verif/tb_nfa_epsilon_closure.sv */
// ----------------------------------------------------------------------------
// tb_nfa_epsilon_closure
// Drives add-edge and closure transactions into the block: a directed opening,
// then random phases with sender gaps, receiver stalls and a long output
// hold-off. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_nfa_epsilon_closure;
    import nec_pkg::*;

    localparam int NUM_STATES   = 16;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 350;
    localparam longint TIMEOUT_NS = 5_000_000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               i_mode;
    logic [STATE_W-1:0] i_from_state;
    logic [STATE_W-1:0] i_to_state;
    logic [SET_W-1:0]   i_start_set;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [SET_W-1:0]   o_closure_set;

    int fail_count;
    int pending;
    int send_idle_pct;
    int stall_pct;
    bit hold_req;

    nfa_epsilon_closure #(
        .NUM_STATES(NUM_STATES)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_mode       (i_mode),
        .i_from_state (i_from_state),
        .i_to_state   (i_to_state),
        .i_start_set  (i_start_set),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_closure_set(o_closure_set)
    );

    nfa_epsilon_closure_checker #(
        .NUM_STATES(NUM_STATES)
    ) u_closure_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_mode       (i_mode),
        .i_from_state (i_from_state),
        .i_to_state   (i_to_state),
        .i_start_set  (i_start_set),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_closure_set(o_closure_set),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    // Receiver: random stalls, or one long hold-off when requested.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // Offer one transaction and return at the edge that accepts it.
    task automatic send_item(input logic mode, input logic [STATE_W-1:0] from_s,
                             input logic [STATE_W-1:0] to_s,
                             input logic [SET_W-1:0] start_s);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_mode       <= mode;
        i_from_state <= from_s;
        i_to_state   <= to_s;
        i_start_set  <= start_s;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Mostly sparse closure queries; edges hop a short way forward unless
    // any_edges allows back edges and cycles.
    task automatic random_burst(input int count, input bit any_edges);
        logic [STATE_W-1:0] from_s;
        logic [STATE_W-1:0] to_s;
        logic [SET_W-1:0]   start_s;
        int                 pick;
        for (int k = 0; k < count; k++) begin
            from_s  = STATE_W'($urandom_range(0, 15));
            to_s    = STATE_W'($urandom_range(0, 15));
            start_s = SET_W'($urandom);
            if ($urandom_range(0, 99) < (any_edges ? 8 : 4)) begin
                if (!any_edges)
                    to_s = (from_s >= 4'd13) ? STATE_W'($urandom_range(from_s, 15))
                                             : from_s + STATE_W'($urandom_range(1, 3));
                send_item(MODE_ADD, from_s, to_s, start_s);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                    start_s = SET_W'(1) << $urandom_range(0, 15);
                else if (pick < 85)
                    start_s = (SET_W'(1) << $urandom_range(0, 15))
                            | (SET_W'(1) << $urandom_range(0, 15));
                send_item(MODE_CLOSE, from_s, to_s, start_s);
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_mode        = MODE_ADD;
        i_from_state  = '0;
        i_to_state    = '0;
        i_start_set   = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_req      = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty store, extreme start sets, self and duplicate edges.
        send_item(MODE_CLOSE, 4'd0,  4'd0,  16'h0000);
        send_item(MODE_CLOSE, 4'd15, 4'd15, 16'hFFFF);
        send_item(MODE_CLOSE, 4'd0,  4'd0,  16'h0001);
        send_item(MODE_ADD,   4'd0,  4'd0,  16'hFFFF);
        send_item(MODE_ADD,   4'd0,  4'd15, 16'h0000);
        send_item(MODE_ADD,   4'd0,  4'd15, 16'hA5A5);
        send_item(MODE_ADD,   4'd15, 4'd15, 16'h5A5A);
        send_item(MODE_CLOSE, 4'd15, 4'd15, 16'h0001);
        send_item(MODE_CLOSE, 4'd7,  4'd3,  16'h8000);
        send_item(MODE_ADD,   4'd7,  4'd8,  16'hFFFF);
        send_item(MODE_ADD,   4'd8,  4'd9,  16'h0000);
        send_item(MODE_CLOSE, 4'd0,  4'd0,  16'h0080);
        send_item(MODE_CLOSE, 4'd15, 4'd0,  16'h0100);
        send_item(MODE_CLOSE, 4'd0,  4'd15, 16'hFFFF);
        send_item(MODE_CLOSE, 4'd15, 4'd0,  16'h0000);

        random_burst(PHASE_ITEMS, 1'b0);
        send_idle_pct = 70;
        stall_pct     = 0;
        random_burst(PHASE_ITEMS, 1'b0);
        send_idle_pct = 0;
        stall_pct     = 70;
        random_burst(PHASE_ITEMS, 1'b0);
        send_idle_pct = 21;
        stall_pct     = 21;
        random_burst(PHASE_ITEMS, 1'b0);
        // Hold the output off while the sender keeps pushing.
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_req      = 1'b1;
        random_burst(PHASE_ITEMS, 1'b1);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/nec_pkg.sv
hdl/nec_ctrl.sv
hdl/nec_dp.sv
hdl/nfa_epsilon_closure.sv
verif/nfa_epsilon_closure_checker.sv
verif/tb_nfa_epsilon_closure.sv
